>>> src/pmq_pkg.sv
`timescale 1ns / 1ps
package pmq_pkg;
    localparam int NUM_KINDS   = 14;
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int KIND_W      = 4;
    localparam int TGT_W       = 16;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int KSEL_W      = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_PULL   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef logic [TAG_BITS-1:0] tag_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [TGT_W-1:0] target;
        logic [KIND_W-1:0] event_kind;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [KIND_W-1:0] out_kind;
        logic [TGT_W-1:0]  out_target;
        logic              overflow;
    } rsp_t;

    // command from the top level to every queue cell
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
        tag_t tag;
    } cell_cmd_t;

    // status a cell reports back
    typedef struct packed {
        logic busy;
        logic full;
        logic nonempty;
        tag_t head;
    } cell_sts_t;

    function automatic tag_t to_tag(input logic [TGT_W-1:0] t);
        logic [TAG_BITS+TGT_W-1:0] w;
        w = {{TAG_BITS{1'b0}}, t};
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [TGT_W-1:0] from_tag(input tag_t t);
        logic [TAG_BITS+TGT_W-1:0] w;
        w = {{TGT_W{1'b0}}, t};
        return w[TGT_W-1:0];
    endfunction
endpackage

>>> src/pmq_if.sv
`timescale 1ns / 1ps
interface pmq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/pmq_cell.sv
`timescale 1ns / 1ps
// One FIFO; entries sit in a shift line, slot 0 is the head.
// Flush compacts one slot per cycle: the scan walks the line, copying kept
// entries down to a write pointer.
module pmq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pmq_pkg::cell_cmd_t  cmd,
    output pmq_pkg::cell_sts_t  sts
);
    pmq_pkg::tag_t                  mem_reg [pmq_pkg::QUEUE_DEPTH];
    logic [pmq_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [pmq_pkg::CNT_W-1:0]      rd_reg, rd_next;
    logic [pmq_pkg::CNT_W-1:0]      wr_reg, wr_next;
    logic                           scan_reg, scan_next;
    pmq_pkg::tag_t                  ftag_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        scan_next = scan_reg;
        if (scan_reg)
        begin
            if (rd_reg == cnt_reg)
            begin
                scan_next = 1'b0;
                cnt_next  = wr_reg;
            end
            else
            begin
                rd_next = rd_reg + 1'b1;
                if (mem_reg[rd_reg[pmq_pkg::QIDX_W-1:0]] != ftag_reg)
                    wr_next = wr_reg + 1'b1;
            end
        end
        else if (cmd.flush)
        begin
            scan_next = 1'b1;
            rd_next   = '0;
            wr_next   = '0;
        end
        else if (cmd.push && cnt_reg != pmq_pkg::CNT_W'(pmq_pkg::QUEUE_DEPTH))
            cnt_next = cnt_reg + 1'b1;
        else if (cmd.pop && cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rd_reg   <= '0;
            wr_reg   <= '0;
            scan_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!scan_reg && cmd.flush)
            ftag_reg <= cmd.tag;
        if (scan_reg)
        begin
            if (rd_reg != cnt_reg)
                mem_reg[wr_reg[pmq_pkg::QIDX_W-1:0]] <=
                    mem_reg[rd_reg[pmq_pkg::QIDX_W-1:0]];
        end
        else if (cmd.push && cnt_reg != pmq_pkg::CNT_W'(pmq_pkg::QUEUE_DEPTH))
            mem_reg[cnt_reg[pmq_pkg::QIDX_W-1:0]] <= cmd.tag;
        else if (cmd.pop && cnt_reg != '0)
            for (int i = 0; i < pmq_pkg::QUEUE_DEPTH - 1; i++)
                mem_reg[i] <= mem_reg[i+1];
    end

    assign sts.busy     = scan_reg;
    assign sts.full     = (cnt_reg == pmq_pkg::CNT_W'(pmq_pkg::QUEUE_DEPTH));
    assign sts.nonempty = (cnt_reg != '0);
    assign sts.head     = mem_reg[0];
endmodule

>>> src/priority_multi_queue_with_tag_flush_unit.sv
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | action, target, event_kind
// rsp     | out | found, out_kind, out_target, overflow
// Add and pull: the result is registered when the beat is taken; req is taken
// only while no beat is held in rsp.
// Remove: every cell compacts its own line in parallel; the result turns valid
// once wait_reg sees that no cell is busy any more.
// rsp stall holds the result register; the next req waits for it to drain.
// Reset clears all counts; tag storage is not cleared.
module priority_multi_queue_with_tag_flush_unit (
    input logic clk,
    input logic rst_n,
    pmq_if.sink   req,
    pmq_if.source rsp
);
    pmq_pkg::cell_cmd_t cmd [pmq_pkg::NUM_KINDS];
    pmq_pkg::cell_sts_t sts [pmq_pkg::NUM_KINDS];
    logic [pmq_pkg::NUM_KINDS-1:0] busy_v;

    logic       rvalid_reg;
    logic       wait_reg;      // remove in progress
    pmq_pkg::rsp_t rdata_reg;
    pmq_pkg::rsp_t rdata_next;
    pmq_pkg::req_t r;
    logic       acc;
    logic       any_busy;

    assign r   = req.data;
    assign acc = req.valid && req.ready;

    // priority pick over the cells (fixed low index first)
    logic                         hit;
    logic [pmq_pkg::KSEL_W-1:0]   hk;
    pmq_pkg::tag_t                ht;
    always_comb
    begin
        hit = 1'b0;
        hk  = '0;
        ht  = '0;
        for (int k = pmq_pkg::NUM_KINDS - 1; k >= 0; k--)
            if (sts[k].nonempty)
            begin
                hit = 1'b1;
                hk  = pmq_pkg::KSEL_W'(k);
                ht  = sts[k].head;
            end
    end

    genvar g;
    generate
        for (g = 0; g < pmq_pkg::NUM_KINDS; g++)
        begin : g_cell
            always_comb
            begin
                cmd[g].tag   = pmq_pkg::to_tag(r.target);
                cmd[g].push  = acc && r.action == pmq_pkg::ACT_ADD &&
                               {1'b0, r.event_kind} == 5'(g);
                cmd[g].pop   = acc && r.action == pmq_pkg::ACT_PULL &&
                               hit && hk == pmq_pkg::KSEL_W'(g);
                cmd[g].flush = acc && r.action == pmq_pkg::ACT_REMOVE;
            end
            assign busy_v[g] = sts[g].busy;
            pmq_cell u_cell (.clk(clk), .rst_n(rst_n), .cmd(cmd[g]), .sts(sts[g]));
        end
    endgenerate

    assign any_busy  = |busy_v;
    assign req.ready = !rvalid_reg && !wait_reg;
    assign rsp.valid = rvalid_reg;
    assign rsp.data  = rdata_reg;

    logic add_ovf;
    always_comb
    begin
        add_ovf = 1'b1;
        for (int k = 0; k < pmq_pkg::NUM_KINDS; k++)
            if ({1'b0, r.event_kind} == 5'(k))
                add_ovf = sts[k].full;
    end

    // result of the beat on req; unused fields stay zero
    always_comb
    begin
        rdata_next = '0;
        case (r.action)
            pmq_pkg::ACT_ADD:
                rdata_next.overflow = add_ovf;
            pmq_pkg::ACT_PULL:
            begin
                rdata_next.found      = hit;
                rdata_next.out_kind   = pmq_pkg::KIND_W'(hk);
                rdata_next.out_target = pmq_pkg::from_tag(ht);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            wait_reg   <= 1'b0;
            rdata_reg  <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                rvalid_reg <= 1'b0;
            if (wait_reg && !any_busy)
            begin
                wait_reg   <= 1'b0;
                rvalid_reg <= 1'b1;
            end
            if (acc)
            begin
                rdata_reg <= rdata_next;
                case (r.action)
                    pmq_pkg::ACT_REMOVE: wait_reg <= 1'b1;
                    default: rvalid_reg <= 1'b1;
                endcase
            end
        end
    end

    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        any_busy |-> !req.ready) else $error("req taken during flush");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("rsp dropped");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(rvalid_reg && wait_reg)) else $error("overlap");
endmodule
